// ===== hw/rtl/ppm_pkg.sv =====
// Shared types and constants of the P6 stream parser.
package ppm_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_MAGIC  = 2'd0,
    ERR_NUMBER = 2'd1,
    ERR_RANGE  = 2'd2,
    ERR_SHORT  = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    PH_P, PH_6,
    PH_W_SKIP, PH_W_DIG,
    PH_H_SKIP, PH_H_DIG,
    PH_M_SKIP, PH_M_DIG,
    PH_PIX, PH_WAIT
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCALE,
    BK_EMIT,
    BK_ERR
  } back_e;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int SAMPLE_LIMIT = 255;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;

  localparam int SCALE_STEPS = 16;
  localparam int SCALE_CNT_W = 5;

  // One queue entry: a primary result, optionally followed by an
  // incomplete-data error.
  typedef struct packed {
    kind_e       kind;
    err_e        code;
    logic        err_after;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [11:0] col;
    logic [12:0] width;
    logic [12:0] height;
    logic [7:0]  max_sample;
    logic        last_pixel;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t ent;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } q_rd_t;

  typedef struct packed {
    kind_e       kind;
    err_e        error_code;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [11:0] row_bottom_up;
    logic [11:0] column;
    logic [12:0] width;
    logic [12:0] height;
    logic [7:0]  max_sample;
    logic        last_pixel;
  } res_t;

endpackage

// ===== hw/rtl/ppm_byte_if.sv =====
// Input byte channel of the P6 stream parser.
interface ppm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/ppm_res_if.sv =====
// Result channel of the P6 stream parser.
interface ppm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  error_code;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [11:0] row_bottom_up;
  logic [11:0] column;
  logic [12:0] width;
  logic [12:0] height;
  logic [7:0]  max_sample;
  logic        last_pixel;

  modport source (
    output valid, input ready,
    output kind, output error_code, output red, output green, output blue,
    output row_bottom_up, output column, output width, output height,
    output max_sample, output last_pixel
  );
  modport sink (
    input valid, output ready,
    input kind, input error_code, input red, input green, input blue,
    input row_bottom_up, input column, input width, input height,
    input max_sample, input last_pixel
  );
endinterface

// ===== hw/rtl/ppm_p6_stream_parser.sv =====
// Top level of the streaming binary PPM (P6) parser.
//
// Takes one byte of a P6 buffer per request on byte_i, with last_byte set on
// the buffer's final byte, and returns header, pixel and error results on
// res_o. The header (magic "P6", decimal width, height and maximum sample,
// separated by whitespace and '#' comments running to CR or LF) is checked
// against MAX_DIM and 255; one whitespace byte after the maximum sample is
// eaten, then RGB byte triples become pixels with a bottom-up row and a
// column, each sample scaled to round(s*65535/max) and saturated. After an
// error nothing more is reported until the final byte; bytes after the
// image are ignored; the final byte always returns the parser to the start.
// Rate: the parser front end takes one byte per cycle as long as its
// four-entry queue has room. The back end takes one queue entry at a
// time: a header or error result goes from idle straight to emit, a pixel
// first through the scale state, where the 16-step bit-serial divider
// does the scaling (three in parallel, one per color); an incomplete-data
// error that trails a result follows from the error state after emit.
// Results wait in a single output register; while one is held off by
// res_o.ready the front end keeps parsing until the queue is full.
module ppm_p6_stream_parser #(
  parameter int MAX_DIM = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppm_byte_if.sink   byte_i,
  ppm_res_if.source  res_o
);

  ppm_pkg::q_wr_t q_wr;
  ppm_pkg::q_rd_t q_rd;
  logic           q_full;
  logic           q_pop;

  // parser: header state machine and pixel gathering
  ppm_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i,
    .rst_ni,
    .byte_i,
    .q_full_i(q_full),
    .q_wr_o  (q_wr)
  );

  // decouples parsing from scaling
  ppm_queue u_queue (
    .clk_i,
    .rst_ni,
    .q_wr_i(q_wr),
    .full_o(q_full),
    .pop_i (q_pop),
    .q_rd_o(q_rd)
  );

  // scaling and result output
  ppm_back u_back (
    .clk_i,
    .rst_ni,
    .q_rd_i(q_rd),
    .pop_o (q_pop),
    .res_o
  );

`ifndef SYNTHESIS
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr.push |-> !q_full)
    else $error("queue request while full");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_rd.valid)
    else $error("queue pop while empty");

  a_quiet_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind != ppm_pkg::KIND_PIXEL)) |->
      (res_o.red == 16'd0 && res_o.green == 16'd0 && res_o.blue == 16'd0 &&
       res_o.last_pixel == 1'b0))
    else $error("pixel fields set on a non-pixel result");
`endif

endmodule

// ===== hw/rtl/ppm_front.sv =====
// Byte parser: header state machine, pixel gathering, queue requests.
module ppm_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ppm_byte_if.sink         byte_i,
  input  logic             q_full_i,
  output ppm_pkg::q_wr_t   q_wr_o
);

  localparam int NUM_CAP = (MAX_DIM > ppm_pkg::SAMPLE_LIMIT) ? MAX_DIM : ppm_pkg::SAMPLE_LIMIT;
  localparam int AW      = $clog2(NUM_CAP + 1);
  localparam int CW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [AW-1:0] DIM_LIM  = AW'(MAX_DIM);
  localparam logic [AW-1:0] SAMP_LIM = AW'(ppm_pkg::SAMPLE_LIMIT);
  localparam logic [AW+3:0] CAP_V    = (AW+4)'(NUM_CAP);

  ppm_pkg::phase_e phase_q, phase_d;
  logic            inc_q, inc_d;
  logic [AW-1:0]   acc_q, acc_d;
  logic            big_q, big_d;
  logic [AW-1:0]   w_q, w_d;
  logic [AW-1:0]   h_q, h_d;
  logic [1:0]      ch_q, ch_d;
  logic [15:0]     rg_q, rg_d;
  logic [CW-1:0]   col_q, col_d;
  logic [CW-1:0]   row_q, row_d;

  logic [7:0]    c;
  logic          last, take;
  logic          is_ws, is_dig, is_hash, is_eol, is_mgrp;
  logic [3:0]    dval;
  logic [AW+3:0] sum;
  logic          add_big, big_add;
  logic [AW-1:0] acc_add, lim;
  logic          bad_cur, bad_add, bad_dig;
  logic          skip_err, skip_dig;
  logic [AW:0]   col_nx, row_nx;
  logic          col_wrap, lp;
  logic [AW-1:0] row_calc;

  logic            te, hdr, end_hdr, end_ev, pb, pix_ev, hdr_out;
  ppm_pkg::err_e   te_code, end_code;
  logic [AW-1:0]   hdr_m;

  assign c    = byte_i.data_byte;
  assign last = byte_i.last_byte;
  assign byte_i.ready = !q_full_i;
  assign take = byte_i.valid && !q_full_i;

  assign is_ws   = (c == ppm_pkg::CH_SPACE) || (c >= ppm_pkg::CH_TAB && c <= ppm_pkg::CH_CR);
  assign is_dig  = (c >= ppm_pkg::CH_ZERO) && (c <= ppm_pkg::CH_NINE);
  assign is_hash = (c == ppm_pkg::CH_HASH);
  assign is_eol  = (c == ppm_pkg::CH_LF) || (c == ppm_pkg::CH_CR);
  assign dval    = c[3:0];
  assign is_mgrp = (phase_q == ppm_pkg::PH_M_SKIP) || (phase_q == ppm_pkg::PH_M_DIG);
  assign lim     = is_mgrp ? SAMP_LIM : DIM_LIM;

  // Decimal accumulate; past the cap only the overflow flag moves.
  assign sum     = (AW+4)'(acc_q) * (AW+4)'(10) + (AW+4)'(dval);
  assign add_big = sum > CAP_V;
  assign acc_add = add_big ? acc_q : AW'(sum);
  assign big_add = big_q | add_big;

  assign bad_cur = big_q || (acc_q == '0) || (acc_q > lim);
  assign bad_add = big_add || (acc_add == '0) || (acc_add > lim);
  assign bad_dig = (dval == 4'd0) || (AW'(dval) > lim);

  assign skip_dig = !inc_q && is_dig;
  assign skip_err = !inc_q && !is_ws && !is_hash && !is_dig;

  assign col_nx   = (AW+1)'(col_q) + (AW+1)'(1);
  assign row_nx   = (AW+1)'(row_q) + (AW+1)'(1);
  assign col_wrap = col_nx >= (AW+1)'(w_q);
  assign lp       = col_wrap && (row_nx >= (AW+1)'(h_q));
  assign row_calc = h_q - AW'(1) - AW'(row_q);

  // Classification of the byte: errors, results and end-of-buffer outcome.
  always_comb begin
    te       = 1'b0;
    te_code  = ppm_pkg::ERR_MAGIC;
    hdr      = 1'b0;
    end_hdr  = 1'b0;
    end_ev   = 1'b0;
    end_code = ppm_pkg::ERR_MAGIC;
    hdr_m    = acc_q;
    pb       = 1'b0;
    unique case (phase_q) inside
      ppm_pkg::PH_P: begin
        te       = (c != ppm_pkg::CH_P);
        end_ev   = 1'b1;
        end_code = ppm_pkg::ERR_MAGIC;
      end
      ppm_pkg::PH_6: begin
        te       = (c != ppm_pkg::CH_6);
        end_ev   = 1'b1;
        end_code = ppm_pkg::ERR_NUMBER;
      end
      ppm_pkg::PH_W_SKIP, ppm_pkg::PH_H_SKIP, ppm_pkg::PH_M_SKIP: begin
        te       = skip_err;
        te_code  = ppm_pkg::ERR_NUMBER;
        end_ev   = 1'b1;
        end_code = ppm_pkg::ERR_NUMBER;
        if (skip_dig) begin
          if (bad_dig) begin
            end_code = ppm_pkg::ERR_RANGE;
          end else if (is_mgrp) begin
            end_hdr  = 1'b1;
            hdr_m    = AW'(dval);
            end_code = ppm_pkg::ERR_SHORT;
          end
        end
      end
      ppm_pkg::PH_W_DIG, ppm_pkg::PH_H_DIG, ppm_pkg::PH_M_DIG: begin
        if (is_dig) begin
          end_ev = 1'b1;
          if (bad_add) begin
            end_code = ppm_pkg::ERR_RANGE;
          end else if (is_mgrp) begin
            end_hdr  = 1'b1;
            hdr_m    = acc_add;
            end_code = ppm_pkg::ERR_SHORT;
          end else begin
            end_code = ppm_pkg::ERR_NUMBER;
          end
        end else if (bad_cur) begin
          te      = 1'b1;
          te_code = ppm_pkg::ERR_RANGE;
        end else if (is_mgrp) begin
          hdr      = 1'b1;
          pb       = !is_ws;
          end_ev   = 1'b1;
          end_code = ppm_pkg::ERR_SHORT;
        end else begin
          // number ended by this byte, which then starts the next skip
          te       = !is_ws && !is_hash;
          te_code  = ppm_pkg::ERR_NUMBER;
          end_ev   = 1'b1;
          end_code = ppm_pkg::ERR_NUMBER;
        end
      end
      ppm_pkg::PH_PIX: begin
        pb       = 1'b1;
        end_ev   = !((ch_q == 2'd2) && lp);
        end_code = ppm_pkg::ERR_SHORT;
      end
      default: begin
      end
    endcase
  end

  assign pix_ev  = pb && (ch_q == 2'd2);
  assign hdr_out = hdr || (last && end_hdr);

  // Queue request built from the classification.
  always_comb begin
    q_wr_o = '0;
    if (te) begin
      q_wr_o.push     = take;
      q_wr_o.ent.kind = ppm_pkg::KIND_ERROR;
      q_wr_o.ent.code = te_code;
    end else if (hdr_out) begin
      q_wr_o.push           = take;
      q_wr_o.ent.kind       = ppm_pkg::KIND_HEADER;
      q_wr_o.ent.err_after  = last && end_ev;
      q_wr_o.ent.width      = 13'(w_q);
      q_wr_o.ent.height     = 13'(h_q);
      q_wr_o.ent.max_sample = 8'(hdr_m);
    end else if (pix_ev) begin
      q_wr_o.push           = take;
      q_wr_o.ent.kind       = ppm_pkg::KIND_PIXEL;
      q_wr_o.ent.err_after  = last && end_ev;
      q_wr_o.ent.red        = rg_q[15:8];
      q_wr_o.ent.green      = rg_q[7:0];
      q_wr_o.ent.blue       = c;
      q_wr_o.ent.row        = 12'(row_calc);
      q_wr_o.ent.col        = 12'(col_q);
      q_wr_o.ent.last_pixel = lp;
    end else if (last && end_ev) begin
      q_wr_o.push     = take;
      q_wr_o.ent.kind = ppm_pkg::KIND_ERROR;
      q_wr_o.ent.code = end_code;
    end
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    inc_d   = inc_q;
    acc_d   = acc_q;
    big_d   = big_q;
    w_d     = w_q;
    h_d     = h_q;
    ch_d    = ch_q;
    rg_d    = rg_q;
    col_d   = col_q;
    row_d   = row_q;
    if (take) begin
      unique case (phase_q) inside
        ppm_pkg::PH_P: phase_d = ppm_pkg::PH_6;
        ppm_pkg::PH_6: phase_d = ppm_pkg::PH_W_SKIP;
        ppm_pkg::PH_W_SKIP, ppm_pkg::PH_H_SKIP, ppm_pkg::PH_M_SKIP: begin
          if (inc_q) begin
            if (is_eol) inc_d = 1'b0;
          end else if (is_hash) begin
            inc_d = 1'b1;
          end else if (is_dig) begin
            acc_d   = AW'(dval);
            big_d   = 1'b0;
            phase_d = (phase_q == ppm_pkg::PH_W_SKIP) ? ppm_pkg::PH_W_DIG :
                      (phase_q == ppm_pkg::PH_H_SKIP) ? ppm_pkg::PH_H_DIG :
                                                        ppm_pkg::PH_M_DIG;
          end
        end
        ppm_pkg::PH_W_DIG, ppm_pkg::PH_H_DIG, ppm_pkg::PH_M_DIG: begin
          if (is_dig) begin
            acc_d = acc_add;
            big_d = big_add;
          end else if (phase_q == ppm_pkg::PH_W_DIG) begin
            w_d     = acc_q;
            inc_d   = is_hash;
            phase_d = ppm_pkg::PH_H_SKIP;
          end else if (phase_q == ppm_pkg::PH_H_DIG) begin
            h_d     = acc_q;
            inc_d   = is_hash;
            phase_d = ppm_pkg::PH_M_SKIP;
          end else begin
            inc_d   = 1'b0;
            phase_d = ppm_pkg::PH_PIX;
          end
        end
        default: begin
        end
      endcase
      if (pb) begin
        unique case (ch_q)
          2'd0: begin
            rg_d[15:8] = c;
            ch_d       = 2'd1;
          end
          2'd1: begin
            rg_d[7:0] = c;
            ch_d      = 2'd2;
          end
          default: begin
            ch_d = 2'd0;
            if (lp) begin
              phase_d = ppm_pkg::PH_WAIT;
            end else if (col_wrap) begin
              col_d = '0;
              row_d = row_q + CW'(1);
            end else begin
              col_d = CW'(col_nx);
            end
          end
        endcase
      end
      if (te) phase_d = ppm_pkg::PH_WAIT;
      if (last) begin
        phase_d = ppm_pkg::PH_P;
        inc_d   = 1'b0;
        acc_d   = '0;
        big_d   = 1'b0;
        w_d     = '0;
        h_d     = '0;
        ch_d    = 2'd0;
        rg_d    = '0;
        col_d   = '0;
        row_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ppm_pkg::PH_P;
      inc_q   <= 1'b0;
      acc_q   <= '0;
      big_q   <= 1'b0;
      w_q     <= '0;
      h_q     <= '0;
      ch_q    <= 2'd0;
      rg_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      phase_q <= phase_d;
      inc_q   <= inc_d;
      acc_q   <= acc_d;
      big_q   <= big_d;
      w_q     <= w_d;
      h_q     <= h_d;
      ch_q    <= ch_d;
      rg_q    <= rg_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

// ===== hw/rtl/ppm_queue.sv =====
// Short entry queue between the parser and the result sequencer.
module ppm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ppm_pkg::q_wr_t q_wr_i,
  output logic           full_o,
  input  logic           pop_i,
  output ppm_pkg::q_rd_t q_rd_o
);

  ppm_pkg::qent_t             mem_q [ppm_pkg::QDEPTH];
  logic [ppm_pkg::QPTR_W-1:0] wp_q, rp_q;
  logic [ppm_pkg::QPTR_W:0]   cnt_q;
  logic                       push, pop;

  assign full_o       = (cnt_q == (ppm_pkg::QPTR_W+1)'(ppm_pkg::QDEPTH));
  assign q_rd_o.valid = (cnt_q != '0);
  assign q_rd_o.ent   = mem_q[rp_q];
  assign push         = q_wr_i.push && !full_o;
  assign pop          = pop_i && q_rd_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + ppm_pkg::QPTR_W'(1);
      if (pop)  rp_q <= rp_q + ppm_pkg::QPTR_W'(1);
      cnt_q <= cnt_q + (ppm_pkg::QPTR_W+1)'(push) - (ppm_pkg::QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= q_wr_i.ent;
  end

endmodule

// ===== hw/rtl/ppm_scale.sv =====
// Sample scaler: round(s*65535/max) by restoring division, one bit a cycle.
module ppm_scale (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [7:0]  sample_i,
  input  logic [7:0]  max_i,
  output logic        busy_o,
  output logic [15:0] value_o
);

  logic [ppm_pkg::SCALE_CNT_W-1:0] cnt_q;
  logic [8:0]  rem_q, rem_d;
  logic [8:0]  div_q;
  logic [15:0] lo_q, quo_q;
  logic        sat_q;
  logic [24:0] num;
  logic [9:0]  trial;
  logic        ge;

  // 2*s*65535 + max, as s<<17 - s<<1 + max
  assign num   = (25'(sample_i) << 17) - (25'(sample_i) << 1) + 25'(max_i);
  assign trial = {rem_q, lo_q[15]};
  assign ge    = trial >= {1'b0, div_q};
  assign rem_d = ge ? 9'(trial - {1'b0, div_q}) : trial[8:0];

  assign busy_o  = (cnt_q != '0);
  assign value_o = sat_q ? 16'hffff : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= ppm_pkg::SCALE_CNT_W'(ppm_pkg::SCALE_STEPS);
    end else if (busy_o) begin
      cnt_q <= cnt_q - ppm_pkg::SCALE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // at or above max the quotient is 65535 or more
      sat_q <= (sample_i >= max_i);
      div_q <= {max_i, 1'b0};
      rem_q <= num[24:16];
      lo_q  <= num[15:0];
      quo_q <= '0;
    end else if (busy_o) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[14:0], 1'b0};
      quo_q <= {quo_q[14:0], ge};
    end
  end

endmodule

// ===== hw/rtl/ppm_back.sv =====
// Result sequencer: pops entries, scales pixels, drives the result register.
module ppm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ppm_pkg::q_rd_t q_rd_i,
  output logic           pop_o,
  ppm_res_if.source      res_o
);

  ppm_pkg::back_e st_q, st_d;
  ppm_pkg::qent_t ent_q;
  ppm_pkg::res_t  out_q, out_d;
  logic [7:0]     m_q;
  logic           ov_q;
  logic           slot_free, start, load;
  logic [2:0]     busy;
  logic [15:0]    red_s, green_s, blue_s;

  assign slot_free = !ov_q || res_o.ready;

  ppm_scale u_scale_r (
    .clk_i, .rst_ni, .start_i(start), .sample_i(q_rd_i.ent.red), .max_i(m_q),
    .busy_o(busy[0]), .value_o(red_s)
  );
  ppm_scale u_scale_g (
    .clk_i, .rst_ni, .start_i(start), .sample_i(q_rd_i.ent.green), .max_i(m_q),
    .busy_o(busy[1]), .value_o(green_s)
  );
  ppm_scale u_scale_b (
    .clk_i, .rst_ni, .start_i(start), .sample_i(q_rd_i.ent.blue), .max_i(m_q),
    .busy_o(busy[2]), .value_o(blue_s)
  );

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ppm_pkg::BK_IDLE: begin
        if (q_rd_i.valid) begin
          st_d = (q_rd_i.ent.kind == ppm_pkg::KIND_PIXEL) ? ppm_pkg::BK_SCALE
                                                          : ppm_pkg::BK_EMIT;
        end
      end
      ppm_pkg::BK_SCALE: if (busy == 3'b000) st_d = ppm_pkg::BK_EMIT;
      ppm_pkg::BK_EMIT: begin
        if (slot_free) st_d = ent_q.err_after ? ppm_pkg::BK_ERR : ppm_pkg::BK_IDLE;
      end
      ppm_pkg::BK_ERR: if (slot_free) st_d = ppm_pkg::BK_IDLE;
      default: st_d = ppm_pkg::BK_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    pop_o = (st_q == ppm_pkg::BK_IDLE) && q_rd_i.valid;
    start = pop_o && (q_rd_i.ent.kind == ppm_pkg::KIND_PIXEL);
    load  = ((st_q == ppm_pkg::BK_EMIT) || (st_q == ppm_pkg::BK_ERR)) && slot_free;
    out_d = '0;
    if (st_q == ppm_pkg::BK_ERR) begin
      out_d.kind       = ppm_pkg::KIND_ERROR;
      out_d.error_code = ppm_pkg::ERR_SHORT;
    end else begin
      out_d.kind = ent_q.kind;
      case (ent_q.kind)
        ppm_pkg::KIND_HEADER: begin
          out_d.width      = ent_q.width;
          out_d.height     = ent_q.height;
          out_d.max_sample = ent_q.max_sample;
        end
        ppm_pkg::KIND_PIXEL: begin
          out_d.red           = red_s;
          out_d.green         = green_s;
          out_d.blue          = blue_s;
          out_d.row_bottom_up = ent_q.row;
          out_d.column        = ent_q.col;
          out_d.last_pixel    = ent_q.last_pixel;
        end
        default: out_d.error_code = ent_q.code;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ppm_pkg::BK_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= q_rd_i.ent;
    if (pop_o && (q_rd_i.ent.kind == ppm_pkg::KIND_HEADER)) m_q <= q_rd_i.ent.max_sample;
    if (load) out_q <= out_d;
  end

  assign res_o.valid         = ov_q;
  assign res_o.kind          = out_q.kind;
  assign res_o.error_code    = out_q.error_code;
  assign res_o.red           = out_q.red;
  assign res_o.green         = out_q.green;
  assign res_o.blue          = out_q.blue;
  assign res_o.row_bottom_up = out_q.row_bottom_up;
  assign res_o.column        = out_q.column;
  assign res_o.width         = out_q.width;
  assign res_o.height        = out_q.height;
  assign res_o.max_sample    = out_q.max_sample;
  assign res_o.last_pixel    = out_q.last_pixel;

endmodule

// ===== bench/ppm_p6_stream_parser_tb.sv =====
// Self-checking testbench for the P6 stream parser against a parse predictor.
`timescale 1ns / 100ps

module ppm_p6_stream_parser_tb;
  import ppm_pkg::*;

  localparam int MAX_DIM = 4096;
  // Largest value the number accumulator holds; longer numbers only flag overflow.
  localparam int NUM_CAP = (MAX_DIM > SAMPLE_LIMIT) ? MAX_DIM : SAMPLE_LIMIT;
  localparam logic [7:0] CH_VT = 8'h0b;
  localparam logic [7:0] CH_FF = 8'h0c;
  localparam int REPORT_CAP = 200;

  logic clk_i;
  logic rst_ni;

  ppm_byte_if byte_if ();
  ppm_res_if  res_if ();

  ppm_p6_stream_parser #(
    .MAX_DIM(MAX_DIM)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .byte_i(byte_if),
    .res_o (res_if)
  );

  // Idle and stall odds in percent, changed per test phase.
  int src_idle_pct;
  int sink_stall_pct;
  // Long receiver hold-off: set by a test, taken over by the receiver process.
  int stall_request;
  int hold_left;

  int unsigned bytes_sent;
  int unsigned buffers_sent;
  int unsigned headers_seen;
  int unsigned pixels_seen;
  int unsigned errors_seen;
  int unsigned mismatches;

  // Results the parser owes us, oldest first.
  res_t pending_results[$];
  // Buffer under construction; the final byte carries last_byte.
  logic [7:0] stream_q[$];

  // ---------------------------------------------------------------------------
  // Parse predictor: its own copy of the header/pixel state machine.
  // ---------------------------------------------------------------------------
  phase_e      ph;
  bit          in_cmt;
  int unsigned acc;
  bit          too_big;
  int unsigned img_w;
  int unsigned img_h;
  int unsigned max_val;
  int unsigned chan;
  int unsigned col_cnt;
  int unsigned row_cnt;
  logic [7:0]  held_r;
  logic [7:0]  held_g;
  bit          err_seen;
  err_e        err_val;

  task automatic reset_parser();
    ph      = PH_P;
    in_cmt  = 1'b0;
    acc     = 0;
    too_big = 1'b0;
    img_w   = 0;
    img_h   = 0;
    max_val = 0;
    chan    = 0;
    col_cnt = 0;
    row_cnt = 0;
    held_r  = '0;
    held_g  = '0;
  endtask

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic res_t blank_res(kind_e k);
    res_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic void flag_error(err_e code);
    err_seen = 1'b1;
    err_val  = code;
  endfunction

  // round(s * 65535 / max) with halves rounding up, clipped to full scale
  function automatic logic [15:0] scale_sample(logic [7:0] s);
    int unsigned q;
    if (max_val == 0) return '0;
    q = (32'(s) * 131070 + max_val) / (2 * max_val);
    return (q > 65535) ? 16'hffff : q[15:0];
  endfunction

  // Byte seen while a number is expected: whitespace, comment or first digit.
  task automatic header_gap(logic [7:0] c, phase_e dig_ph);
    if (in_cmt) begin
      if (c == CH_LF || c == CH_CR) in_cmt = 1'b0;
    end else if (c == CH_HASH) begin
      in_cmt = 1'b1;
    end else if (is_digit(c)) begin
      acc     = c - CH_ZERO;
      too_big = 1'b0;
      ph      = dig_ph;
    end else if (!is_space(c)) begin
      flag_error(ERR_NUMBER);
    end
  endtask

  task automatic add_digit(logic [7:0] c);
    int unsigned v;
    v = acc * 10 + (c - CH_ZERO);
    if (v > NUM_CAP) too_big = 1'b1;
    else acc = v;
  endtask

  // Closes the number of the current digit phase; 0 when out of range.
  function automatic bit close_number();
    int unsigned lim;
    lim = (ph == PH_M_DIG) ? SAMPLE_LIMIT : MAX_DIM;
    if (too_big || acc == 0 || acc > lim) return 1'b0;
    case (ph)
      PH_W_DIG: img_w = acc;
      PH_H_DIG: img_h = acc;
      default:  max_val = acc;
    endcase
    return 1'b1;
  endfunction

  task automatic header_result();
    res_t r;
    r            = blank_res(KIND_HEADER);
    r.width      = 13'(img_w);
    r.height     = 13'(img_h);
    r.max_sample = 8'(max_val);
    pending_results.push_back(r);
  endtask

  task automatic pixel_byte(logic [7:0] c);
    res_t r;
    bit   lp;
    case (chan)
      0: begin
        held_r = c;
        chan   = 1;
      end
      1: begin
        held_g = c;
        chan   = 2;
      end
      default: begin
        chan            = 0;
        lp              = (row_cnt + 1 >= img_h) && (col_cnt + 1 >= img_w);
        r               = blank_res(KIND_PIXEL);
        r.red           = scale_sample(held_r);
        r.green         = scale_sample(held_g);
        r.blue          = scale_sample(c);
        r.row_bottom_up = 12'(img_h - 1 - row_cnt);
        r.column        = 12'(col_cnt);
        r.last_pixel    = lp;
        pending_results.push_back(r);
        if (lp) begin
          ph = PH_WAIT;   // rest of the buffer is ignored
        end else begin
          col_cnt++;
          if (col_cnt >= img_w) begin
            col_cnt = 0;
            row_cnt++;
          end
        end
      end
    endcase
  endtask

  task automatic take_byte(logic [7:0] c);
    case (ph)
      PH_P: if (c != CH_P) flag_error(ERR_MAGIC); else ph = PH_6;
      PH_6: if (c != CH_6) flag_error(ERR_MAGIC); else ph = PH_W_SKIP;
      PH_W_SKIP: header_gap(c, PH_W_DIG);
      PH_H_SKIP: header_gap(c, PH_H_DIG);
      PH_M_SKIP: header_gap(c, PH_M_DIG);
      PH_W_DIG, PH_H_DIG, PH_M_DIG: begin
        if (is_digit(c)) begin
          add_digit(c);
        end else if (!close_number()) begin
          flag_error(ERR_RANGE);
        end else begin
          // the byte that ended the number belongs to what follows
          in_cmt = 1'b0;
          if (ph == PH_W_DIG) begin
            ph = PH_H_SKIP;
            header_gap(c, PH_H_DIG);
          end else if (ph == PH_H_DIG) begin
            ph = PH_M_SKIP;
            header_gap(c, PH_M_DIG);
          end else begin
            header_result();
            ph = PH_PIX;
            if (!is_space(c)) pixel_byte(c);   // no separator: first data byte
          end
        end
      end
      PH_PIX: pixel_byte(c);
      default: ;
    endcase
  endtask

  // Buffer ended with the parse unfinished.
  task automatic end_of_buffer();
    case (ph)
      PH_P, PH_6: flag_error(ERR_MAGIC);
      PH_W_SKIP, PH_H_SKIP, PH_M_SKIP: flag_error(ERR_NUMBER);
      PH_W_DIG, PH_H_DIG: begin
        if (!close_number()) flag_error(ERR_RANGE);
        else flag_error(ERR_NUMBER);
      end
      PH_M_DIG: begin
        if (!close_number()) begin
          flag_error(ERR_RANGE);
        end else begin
          header_result();
          flag_error(ERR_SHORT);
        end
      end
      PH_PIX: flag_error(ERR_SHORT);
      default: ;
    endcase
  endtask

  // Works out the results caused by one accepted byte request.
  task automatic parse_byte(logic [7:0] c, logic is_last);
    res_t r;
    err_seen = 1'b0;
    take_byte(c);
    if (!err_seen && is_last) end_of_buffer();
    if (err_seen) begin
      r            = blank_res(KIND_ERROR);
      r.error_code = err_val;
      pending_results.push_back(r);
      ph = PH_WAIT;     // silent until the final byte
    end
    if (is_last) reset_parser();
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog, receiver and result checker
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Far above the slowest legal run (~2k bytes).
  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls, or a long counted hold-off when a test asks.
  always @(negedge clk_i) begin
    if (stall_request != 0) begin
      hold_left     = stall_request;
      stall_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      else if (mismatches == REPORT_CAP + 1)
        $display("%t: further mismatch reports suppressed", $time);
    end
  endfunction

  // Each result request is matched against the oldest expected result.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%t: unexpected result, kind %0d, with nothing expected", $time,
                 res_if.kind);
      end else begin
        want = pending_results.pop_front();
        case (want.kind)
          KIND_HEADER: headers_seen++;
          KIND_PIXEL:  pixels_seen++;
          default:     errors_seen++;
        endcase
        check_field("kind", want.kind, res_if.kind);
        check_field("error_code", want.error_code, res_if.error_code);
        check_field("red", want.red, res_if.red);
        check_field("green", want.green, res_if.green);
        check_field("blue", want.blue, res_if.blue);
        check_field("row_bottom_up", want.row_bottom_up, res_if.row_bottom_up);
        check_field("column", want.column, res_if.column);
        check_field("width", want.width, res_if.width);
        check_field("height", want.height, res_if.height);
        check_field("max_sample", want.max_sample, res_if.max_sample);
        check_field("last_pixel", want.last_pixel, res_if.last_pixel);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte requests and buffer building
  // ---------------------------------------------------------------------------
  // Entered and left at a falling edge, so valid gets one update per step.
  task automatic send_byte(logic [7:0] value, logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= value;
    byte_if.last_byte <= is_last;
    do @(posedge clk_i); while (!byte_if.ready);
    parse_byte(value, is_last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
    buffers_sent++;
  endtask

  // Drops valid and waits until every owed result has come, then extra cycles.
  task automatic wait_idle(int extra);
    int guard;
    guard = 0;
    byte_if.valid <= 1'b0;
    do begin
      @(negedge clk_i);
      guard++;
    end while (pending_results.size() != 0 && guard < 50000);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic put_byte(logic [7:0] b);
    stream_q.push_back(b);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
  endtask

  task automatic put_num(int unsigned n);
    put_text($sformatf("%0d", n));
  endtask

  task automatic put_pixels(int n);
    repeat (n * 3) stream_q.push_back(8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // Separator: whitespace bytes and '#' comments ended by LF or CR.
  task automatic put_gap();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(4) == 0) begin
        stream_q.push_back(CH_HASH);
        repeat ($urandom_range(0, 6)) stream_q.push_back(8'($urandom_range(32, 126)));
        stream_q.push_back($urandom_range(1) ? CH_LF : CH_CR);
      end else begin
        stream_q.push_back(ws_byte());
      end
    end
  endtask

  // Header number, now and then with a leading zero.
  task automatic put_field(int unsigned n);
    if ($urandom_range(7) == 0) stream_q.push_back(CH_ZERO);
    put_num(n);
  endtask

  // Mostly well-formed images with random content; a share of them has a bad
  // header value, a corrupted header byte, a truncated body or trailing junk,
  // and a few buffers are plain noise.
  task automatic build_random_buffer();
    int unsigned w, h, m, sel, body, head_len;
    sel = $urandom_range(99);
    if (sel < 6) begin
      repeat ($urandom_range(1, 10)) stream_q.push_back(8'($urandom_range(255)));
      return;
    end
    w = ($urandom_range(19) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
    h = (w > 5) ? 1 : $urandom_range(1, 5);
    case ($urandom_range(9))
      0, 1, 2: m = 255;
      3:       m = 1;
      default: m = $urandom_range(1, 255);
    endcase
    if (sel < 12) begin
      case ($urandom_range(2))
        0:       w = $urandom_range(1) ? 0 : MAX_DIM + $urandom_range(1, 9000);
        1:       h = 0;
        default: m = $urandom_range(1) ? 0 : $urandom_range(256, 999);
      endcase
    end
    put_text("P6");
    put_gap();
    put_field(w);
    put_gap();
    put_field(h);
    put_gap();
    put_field(m);
    if ($urandom_range(9) != 0) stream_q.push_back(ws_byte());
    head_len = stream_q.size();
    if (sel >= 12 && sel < 20)
      stream_q[$urandom_range(head_len - 1)] = 8'($urandom_range(255));
    if (sel >= 12) begin
      body = w * h * 3;
      if ($urandom_range(6) == 0) body = $urandom_range(0, body - 1);
    end else begin
      body = $urandom_range(6);
    end
    repeat (body) stream_q.push_back(8'($urandom_range(255)));
    if ($urandom_range(6) == 0)
      repeat ($urandom_range(1, 8)) stream_q.push_back(8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_magic_errors();
    put_text("X");  send_stream();              // wrong first byte
    put_text("PX"); send_stream();              // wrong second byte
    put_text("P");  send_stream();              // buffer ends inside the magic
    put_text("P6"); send_stream();              // ends before the width
    put_text("Q6 1 1 255\nabc"); send_stream(); // one error, then silence
    wait_idle(0);
  endtask

  task automatic test_header_syntax();
    put_text("P6 1x 1 255\n"); send_stream();   // stray byte after the width
    put_text("P6 z"); send_stream();            // stray byte that is also the last
    // comments ended by CR and LF, a number ended by '#', VT and FF as spacing
    put_text("P6\t#c");
    put_byte(CH_CR);
    put_text("2#x\n 1");
    put_byte(CH_VT);
    put_byte(CH_FF);
    put_text("255\n");
    put_pixels(2);
    send_stream();
    wait_idle(0);
  endtask

  task automatic test_header_ranges();
    put_text("P6 0 1 255\n");  send_stream();   // zero width
    put_text("P6 4097 1 255"); send_stream();   // width over the limit
    put_text("P6 1 0 255\n");  send_stream();   // zero height
    put_text("P6 1 1 256 ");   send_stream();   // max sample over 255
    put_text("P6 1 1 0\n");    send_stream();   // zero max sample
    put_text("P6 99999 ");     send_stream();   // number past the accumulator
    put_text("P6 2 2 300");    send_stream();   // bad value closed by buffer end
    wait_idle(0);
  endtask

  task automatic test_short_buffers();
    put_text("P6 2");          send_stream();   // ends inside a good number
    put_text("P6 2 2 25");     send_stream();   // header then incomplete data
    put_text("P6 2 2 255 ");   send_stream();   // header, no data
    put_text("P6 2 2 255\n");  put_pixels(1); put_byte(8'h11); put_byte(8'h22);
    send_stream();                              // one pixel and a partial one
    put_text("P6 1 1 255\n");  put_pixels(1); send_stream();   // exact fit
    wait_idle(0);
  endtask

  task automatic test_sample_scaling();
    put_text("P6 2 1 255\n");
    put_byte(8'h00); put_byte(8'hff); put_byte(8'h80);
    put_byte(8'hff); put_byte(8'h00); put_byte(8'h01);
    send_stream();
    // samples above the maximum saturate; bytes after the image are ignored
    put_text("P6 2 1 1\n");
    put_byte(8'h00); put_byte(8'h01); put_byte(8'h02);
    put_byte(8'hc8); put_byte(8'hff); put_byte(8'h01);
    put_text("junk");
    send_stream();
    // no separator after the max sample: the next byte is already data
    put_text("P6 1 1 7");
    put_byte(8'hff); put_byte(8'h03); put_byte(8'h07);
    put_text("xyz");
    send_stream();
    wait_idle(0);
  endtask

  task automatic test_extreme_dimensions();
    put_text("P6 4096 1 255\n");    put_pixels(2); send_stream();
    put_text("P6 1 0004096 255\n"); put_pixels(2); send_stream();
    wait_idle(0);
  endtask

  task automatic test_random_streams(int src_pct, int sink_pct, int unsigned budget);
    int unsigned start;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start          = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_random_buffer();
      send_stream();
    end
    wait_idle(0);
  endtask

  // Receiver holds off for a long stretch while bytes keep coming, so the
  // result queue fills and the byte channel has to stall.
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    stall_request  = 400;
    put_text("P6 6 6 255\n");
    put_pixels(36);
    send_stream();
    wait_idle(0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    $timeformat(-9, 1, " ns", 0);
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_byte = 1'b0;
    res_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    stall_request     = 0;
    hold_left         = 0;
    bytes_sent        = 0;
    buffers_sent      = 0;
    headers_seen      = 0;
    pixels_seen       = 0;
    errors_seen       = 0;
    mismatches        = 0;
    src_idle_pct      = 36;
    sink_stall_pct    = 55;
    reset_parser();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_magic_errors();
    test_header_syntax();
    test_header_ranges();
    test_short_buffers();
    test_sample_scaling();
    test_extreme_dimensions();
    test_random_streams(36, 55, 220);
    test_random_streams(55, 36, 220);
    test_random_streams(0, 0, 220);
    test_backpressure();

    // room for a trailing pixel plus anything stray
    wait_idle(100);
    if (pending_results.size() != 0) begin
      mismatches += pending_results.size();
      $display("%t: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Run covered %0d bytes in %0d buffers: %0d headers, %0d pixels, %0d errors.",
             bytes_sent, buffers_sent, headers_seen, pixels_seen, errors_seen);
    $display("Idle mixes 36/55, 55/36 and none, plus a 400-cycle receiver hold-off.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
